FILE: hw/rtl/onpa_pkg.sv
// onpa_pkg: shared constants, types and controller states for the omega network
// path allocator
// no dependencies
`default_nettype none

package onpa_pkg;

  localparam int LINES         = 256;
  localparam int LINE_W        = 8;
  localparam int STAGES        = 5;
  localparam int EXTRA_CHOICES = 4;
  localparam int EXTRA_W       = 2;
  localparam int TAG_W         = 2 * LINE_W + EXTRA_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear_we;
    logic load;
    logic next_extra;
    logic mark;
    logic set_hit;
    logic set_miss;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic path_free;
    logic last_extra;
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/onpa_datapath.sv
// onpa_datapath: request registers, per-stage busy memories, extra digit counter
// and result registers; driven by onpa_ctrl commands
// depends on onpa_pkg
`default_nettype none

module onpa_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire onpa_pkg::cmd_t                 cmd,
  input  wire logic [onpa_pkg::LINE_W-1:0]    src_port,
  input  wire logic [onpa_pkg::LINE_W-1:0]    dst_port,
  output onpa_pkg::sts_t                      sts,
  output logic                                found,
  output logic [onpa_pkg::EXTRA_W-1:0]        extra_used
);

  logic [onpa_pkg::LINE_W-1:0]  src_r;
  logic [onpa_pkg::LINE_W-1:0]  dst_r;
  logic [onpa_pkg::EXTRA_W-1:0] extra_r;
  logic [onpa_pkg::LINE_W-1:0]  clr_cnt_r;
  logic                         res_found_r;
  logic [onpa_pkg::EXTRA_W-1:0] res_extra_r;
  logic                         out_found_r;
  logic [onpa_pkg::EXTRA_W-1:0] out_extra_r;
  logic [onpa_pkg::TAG_W-1:0]   tag;
  wire  [onpa_pkg::STAGES-1:0]  busy_rd;

  assign tag = {src_r, extra_r, dst_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r <= src_port;
      dst_r <= dst_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extra_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        extra_r <= '0;
      end else if (cmd.next_extra) begin
        extra_r <= extra_r + onpa_pkg::EXTRA_W'(1);
      end
      if (cmd.clear_we) begin
        clr_cnt_r <= clr_cnt_r + onpa_pkg::LINE_W'(1);
      end
    end
  end

  // one busy memory per stage, each with its own line address
  for (genvar s = 0; s < onpa_pkg::STAGES; s++) begin : g_stage
    logic                        busy_mem [onpa_pkg::LINES];
    logic [onpa_pkg::LINE_W-1:0] line;
    logic [onpa_pkg::LINE_W-1:0] waddr;
    logic                        rd_r;

    assign line  = tag[2*(onpa_pkg::STAGES-1-s) +: onpa_pkg::LINE_W];
    assign waddr = cmd.clear_we ? clr_cnt_r : line;

    always_ff @(posedge clk) begin
      if (cmd.clear_we || cmd.mark) begin
        busy_mem[waddr] <= cmd.mark;
      end
      rd_r <= busy_mem[line];
    end

    assign busy_rd[s] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.set_hit) begin
      res_found_r <= 1'b1;
      res_extra_r <= extra_r;
    end else if (cmd.set_miss) begin
      res_found_r <= 1'b0;
      res_extra_r <= '0;
    end
    if (cmd.load_out) begin
      out_found_r <= res_found_r;
      out_extra_r <= res_extra_r;
    end
  end

  assign sts.clear_done = (clr_cnt_r == onpa_pkg::LINE_W'(onpa_pkg::LINES - 1));
  assign sts.path_free  = ~|busy_rd;
  assign sts.last_extra = (extra_r == onpa_pkg::EXTRA_W'(onpa_pkg::EXTRA_CHOICES - 1));

  assign found      = out_found_r;
  assign extra_used = out_extra_r;

endmodule

`default_nettype wire

FILE: hw/rtl/onpa_ctrl.sv
// onpa_ctrl: controller state machine sequencing clear, lookup, mark and result
// transfer
// depends on onpa_pkg
`default_nettype none

module onpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire onpa_pkg::sts_t sts,
  output onpa_pkg::cmd_t      cmd
);

  onpa_pkg::state_t state_r;
  onpa_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= onpa_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      onpa_pkg::ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (sts.clear_done) begin
          state_nxt = onpa_pkg::ST_IDLE;
        end
      end
      onpa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = onpa_pkg::ST_READ;
        end
      end
      onpa_pkg::ST_READ: begin
        state_nxt = onpa_pkg::ST_CHECK;
      end
      onpa_pkg::ST_CHECK: begin
        priority if (sts.path_free) begin
          cmd.mark    = 1'b1;
          cmd.set_hit = 1'b1;
          state_nxt   = onpa_pkg::ST_RESULT;
        end else if (sts.last_extra) begin
          cmd.set_miss = 1'b1;
          state_nxt    = onpa_pkg::ST_RESULT;
        end else begin
          cmd.next_extra = 1'b1;
          state_nxt      = onpa_pkg::ST_READ;
        end
      end
      onpa_pkg::ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = onpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = onpa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/omega_network_path_allocator.sv
// omega_network_path_allocator: top level joining onpa_ctrl and onpa_datapath
// depends on onpa_pkg, onpa_ctrl, onpa_datapath
// flow: input transfer loads the request, then one read/check pass per extra digit tried (1 to 4),
// then the result registers; a new input is taken only once the result has gone to the output
// register, so a stalled result holds off the next input
// reset: synchronous active-low; then a sweep over all 256 lines clears the busy memories, no
// input accepted during the sweep
`default_nettype none

module omega_network_path_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // src_port [7:0], dst_port [15:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // found [0], extra_used [2:1], zero [7:3]
);

  onpa_pkg::cmd_t                cmd;
  onpa_pkg::sts_t                sts;
  logic                          found;
  logic [onpa_pkg::EXTRA_W-1:0]  extra_used;

  onpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  onpa_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .src_port   (in_tdata[7:0]),
    .dst_port   (in_tdata[15:8]),
    .sts        (sts),
    .found      (found),
    .extra_used (extra_used)
  );

  assign out_tdata = {5'b0, extra_used, found};

  // one request at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a request is in progress");

  // links are marked only for a fully free path
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> (sts.path_free && !cmd.clear_we))
    else $error("links marked for a blocked path");

  // a failed request reports extra digit zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[2:1] == 2'b00))
    else $error("nonzero extra digit on failed request");

endmodule

`default_nettype wire
